// File: design/itoa_pkg.sv
`default_nettype none

package itoa_pkg;

    // Default datapath width for the converted number
    localparam int VALUE_WIDTH_DEFAULT = 64;

    // Digit register: 20 nibbles cover any 64-bit decimal and 16 hex nibbles
    localparam int NUM_DIGITS   = 20;
    localparam int DIGIT_BITS   = 4 * NUM_DIGITS;
    localparam int DIGIT_CNT_W  = $clog2(NUM_DIGITS + 1);

    localparam int COUNT_W      = 31;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Action codes
    localparam logic [2:0] ACT_SDEC = 3'd0;
    localparam logic [2:0] ACT_UDEC = 3'd1;
    localparam logic [2:0] ACT_HEX  = 3'd2;
    localparam logic [2:0] ACT_PTR  = 3'd3;
    localparam logic [2:0] ACT_LIT  = 3'd4;

    // Size codes
    localparam logic [1:0] SIZE_8  = 2'd0;
    localparam logic [1:0] SIZE_16 = 2'd1;
    localparam logic [1:0] SIZE_32 = 2'd2;
    localparam logic [1:0] SIZE_64 = 2'd3;

    // Configuration register indexes
    localparam logic [0:0] CFG_OUTPUT_LIMIT     = 1'b0;
    localparam logic [0:0] CFG_CONVERT_NEWLINES = 1'b1;

    // ASCII codes
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_UPPER = 8'h41;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;
    localparam logic [7:0] ASCII_X     = 8'h78;
    localparam logic [7:0] ASCII_CR    = 8'h0D;
    localparam logic [7:0] ASCII_LF    = 8'h0A;
    localparam logic [3:0] DEC_RADIX   = 4'd10;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MINUS,
        ST_DABBLE,
        ST_ZERO,
        ST_X,
        ST_SCAN,
        ST_DIGIT,
        ST_CR,
        ST_LIT
    } state_t;

    typedef enum logic [2:0] {
        CH_MINUS,
        CH_ZERO,
        CH_X,
        CH_CR,
        CH_LIT,
        CH_DIGIT
    } char_sel_t;

    typedef struct packed {
        logic      load;
        logic      dabble;
        logic      shift;
        logic      emit;
        char_sel_t sel;
        logic      last;
    } cmd_t;

    typedef struct packed {
        logic neg;
        logic crlf;
        logic top_zero;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// File: design/itoa_ctrl.sv
`default_nettype none

module itoa_ctrl #(
    parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEFAULT
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    input  wire logic [2:0]       action,
    output logic                  in_ready,
    input  wire itoa_pkg::status_t sts,
    output itoa_pkg::cmd_t        cmd
);

    localparam int BIT_CNT_W = $clog2(VALUE_WIDTH + 1);
    localparam logic [BIT_CNT_W-1:0] BIT_CNT_LOAD = BIT_CNT_W'(VALUE_WIDTH);
    localparam logic [BIT_CNT_W-1:0] BIT_CNT_ONE  = BIT_CNT_W'(1);
    localparam logic [itoa_pkg::DIGIT_CNT_W-1:0] DIG_LOAD =
        itoa_pkg::DIGIT_CNT_W'(itoa_pkg::NUM_DIGITS);
    localparam logic [itoa_pkg::DIGIT_CNT_W-1:0] DIG_ONE = itoa_pkg::DIGIT_CNT_W'(1);

    itoa_pkg::state_t state_reg, state_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [itoa_pkg::DIGIT_CNT_W-1:0] dig_cnt_reg, dig_cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= itoa_pkg::ST_IDLE;
            bit_cnt_reg <= '0;
            dig_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            dig_cnt_reg <= dig_cnt_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        in_ready     = 1'b0;
        cmd          = '{load: 1'b0, dabble: 1'b0, shift: 1'b0, emit: 1'b0,
                         sel: itoa_pkg::CH_DIGIT, last: 1'b0};
        unique case (state_reg)
            itoa_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load     = 1'b1;
                    bit_cnt_next = BIT_CNT_LOAD;
                    dig_cnt_next = DIG_LOAD;
                    unique case (action)
                        itoa_pkg::ACT_SDEC:
                            state_next = sts.neg ? itoa_pkg::ST_MINUS : itoa_pkg::ST_DABBLE;
                        itoa_pkg::ACT_UDEC: state_next = itoa_pkg::ST_DABBLE;
                        itoa_pkg::ACT_HEX:  state_next = itoa_pkg::ST_SCAN;
                        itoa_pkg::ACT_PTR:  state_next = itoa_pkg::ST_ZERO;
                        itoa_pkg::ACT_LIT:
                            state_next = sts.crlf ? itoa_pkg::ST_CR : itoa_pkg::ST_LIT;
                        default:            state_next = itoa_pkg::ST_IDLE;
                    endcase
                end
            end
            itoa_pkg::ST_MINUS: begin
                cmd.sel = itoa_pkg::CH_MINUS;
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = itoa_pkg::ST_DABBLE;
                end
            end
            itoa_pkg::ST_DABBLE: begin
                cmd.dabble   = 1'b1;
                bit_cnt_next = bit_cnt_reg - BIT_CNT_ONE;
                if (bit_cnt_reg == BIT_CNT_ONE) begin
                    state_next = itoa_pkg::ST_SCAN;
                end
            end
            itoa_pkg::ST_ZERO: begin
                cmd.sel = itoa_pkg::CH_ZERO;
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = itoa_pkg::ST_X;
                end
            end
            itoa_pkg::ST_X: begin
                cmd.sel = itoa_pkg::CH_X;
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = itoa_pkg::ST_SCAN;
                end
            end
            itoa_pkg::ST_SCAN: begin
                // drop leading zeros, keep at least one digit
                if (sts.top_zero && dig_cnt_reg != DIG_ONE) begin
                    cmd.shift    = 1'b1;
                    dig_cnt_next = dig_cnt_reg - DIG_ONE;
                end else begin
                    state_next = itoa_pkg::ST_DIGIT;
                end
            end
            itoa_pkg::ST_DIGIT: begin
                cmd.sel  = itoa_pkg::CH_DIGIT;
                cmd.last = (dig_cnt_reg == DIG_ONE);
                if (sts.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.shift    = 1'b1;
                    dig_cnt_next = dig_cnt_reg - DIG_ONE;
                    if (dig_cnt_reg == DIG_ONE) begin
                        state_next = itoa_pkg::ST_IDLE;
                    end
                end
            end
            itoa_pkg::ST_CR: begin
                cmd.sel = itoa_pkg::CH_CR;
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = itoa_pkg::ST_LIT;
                end
            end
            itoa_pkg::ST_LIT: begin
                cmd.sel  = itoa_pkg::CH_LIT;
                cmd.last = 1'b1;
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = itoa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = itoa_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: design/itoa_dpath.sv
`default_nettype none

module itoa_dpath #(
    parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEFAULT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [0:0]        cfg_index,
    input  wire logic [30:0]       cfg_wdata,
    input  wire logic [2:0]        action,
    input  wire logic [1:0]        size_code,
    input  wire logic [63:0]       value,
    input  wire logic              restart,
    input  wire itoa_pkg::cmd_t    cmd,
    output itoa_pkg::status_t      sts,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output logic [7:0]             out_char,
    output logic                   out_in_limit,
    output logic [itoa_pkg::COUNT_W-1:0] out_position,
    output logic                   out_last
);

    localparam int DB = itoa_pkg::DIGIT_BITS;
    localparam logic [63:0] VW_MASK = (64'd1 << VALUE_WIDTH) - 64'd1;
    localparam logic [6:0]  VW_BITS = 7'(VALUE_WIDTH);

    logic [itoa_pkg::COUNT_W-1:0] limit_reg;
    logic                         conv_reg;
    logic [7:0]                   prev_reg;
    logic [itoa_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [VALUE_WIDTH-1:0]       bin_reg, bin_next;
    logic [DB-1:0]                dig_reg, dig_next;

    logic                         valid_reg;
    logic [7:0]                   char_reg;
    logic                         lim_reg;
    logic [itoa_pkg::COUNT_W-1:0] pos_reg;
    logic                         last_reg;

    logic [63:0] size_mask;
    logic [63:0] v_m;
    logic [63:0] mag;
    logic [6:0]  w_eff;
    logic [6:0]  w_size;
    logic        sign_bit;
    logic [DB-1:0] dig_adj;
    logic [3:0]  top_dig;
    logic [7:0]  dig_char;
    logic [7:0]  emit_char;

    // cut the value to the chosen size, never wider than the datapath
    always_comb begin
        unique case (size_code)
            itoa_pkg::SIZE_8:  begin size_mask = 64'h0000_0000_0000_00FF; w_size = 7'd8;  end
            itoa_pkg::SIZE_16: begin size_mask = 64'h0000_0000_0000_FFFF; w_size = 7'd16; end
            itoa_pkg::SIZE_32: begin size_mask = 64'h0000_0000_FFFF_FFFF; w_size = 7'd32; end
            itoa_pkg::SIZE_64: begin size_mask = 64'hFFFF_FFFF_FFFF_FFFF; w_size = 7'd64; end
            default:           begin size_mask = 64'hFFFF_FFFF_FFFF_FFFF; w_size = 7'd64; end
        endcase
        w_eff    = (w_size > VW_BITS) ? VW_BITS : w_size;
        v_m      = value & size_mask & VW_MASK;
        sign_bit = v_m[6'(w_eff - 7'd1)];
        mag      = (action == itoa_pkg::ACT_SDEC && sign_bit)
                   ? (((~v_m) & size_mask & VW_MASK) + 64'd1) : v_m;
    end

    // add 3 to every BCD digit of five or more ahead of the shift
    always_comb begin
        for (int i = 0; i < itoa_pkg::NUM_DIGITS; i++) begin
            dig_adj[4*i +: 4] = (dig_reg[4*i +: 4] >= 4'd5)
                                ? dig_reg[4*i +: 4] + 4'd3 : dig_reg[4*i +: 4];
        end
    end

    assign top_dig  = dig_reg[DB-1 -: 4];
    assign dig_char = (top_dig < itoa_pkg::DEC_RADIX)
                      ? itoa_pkg::ASCII_ZERO + {4'd0, top_dig}
                      : itoa_pkg::ASCII_UPPER + {4'd0, top_dig - itoa_pkg::DEC_RADIX};

    always_comb begin
        unique case (cmd.sel)
            itoa_pkg::CH_MINUS: emit_char = itoa_pkg::ASCII_MINUS;
            itoa_pkg::CH_ZERO:  emit_char = itoa_pkg::ASCII_ZERO;
            itoa_pkg::CH_X:     emit_char = itoa_pkg::ASCII_X;
            itoa_pkg::CH_CR:    emit_char = itoa_pkg::ASCII_CR;
            itoa_pkg::CH_LIT:   emit_char = prev_reg;
            itoa_pkg::CH_DIGIT: emit_char = dig_char;
            default:            emit_char = dig_char;
        endcase
    end

    always_comb begin
        bin_next   = bin_reg;
        dig_next   = dig_reg;
        count_next = count_reg;
        priority if (cmd.load) begin
            bin_next = mag[VALUE_WIDTH-1:0];
            dig_next = (action == itoa_pkg::ACT_HEX || action == itoa_pkg::ACT_PTR)
                       ? {{(DB-64){1'b0}}, v_m} : '0;
            if (restart) begin
                count_next = '0;
            end
        end else if (cmd.dabble) begin
            dig_next = {dig_adj[DB-2:0], bin_reg[VALUE_WIDTH-1]};
            bin_next = {bin_reg[VALUE_WIDTH-2:0], 1'b0};
        end else if (cmd.shift) begin
            dig_next = {dig_reg[DB-5:0], 4'd0};
        end
        if (cmd.emit && count_reg != itoa_pkg::COUNT_MAX) begin
            count_next = count_reg + itoa_pkg::COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= itoa_pkg::COUNT_MAX;
            conv_reg  <= 1'b0;
            prev_reg  <= 8'd0;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    itoa_pkg::CFG_OUTPUT_LIMIT:     limit_reg <= cfg_wdata;
                    itoa_pkg::CFG_CONVERT_NEWLINES: conv_reg  <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (cmd.load && action == itoa_pkg::ACT_LIT) begin
                prev_reg <= value[7:0];
            end
            count_reg <= count_next;
            if (cmd.emit) begin
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        bin_reg <= bin_next;
        dig_reg <= dig_next;
        if (cmd.emit) begin
            char_reg <= emit_char;
            lim_reg  <= (count_reg < limit_reg);
            pos_reg  <= count_reg;
            last_reg <= cmd.last;
        end
    end

    assign sts.neg      = sign_bit;
    assign sts.crlf     = conv_reg && value[7:0] == itoa_pkg::ASCII_LF
                          && prev_reg != itoa_pkg::ASCII_CR;
    assign sts.top_zero = (top_dig == 4'd0);
    assign sts.out_free = !valid_reg || out_ready;

    assign out_valid    = valid_reg;
    assign out_char     = char_reg;
    assign out_in_limit = lim_reg;
    assign out_position = pos_reg;
    assign out_last     = last_reg;

endmodule

`default_nettype wire

// File: design/integer_to_ascii_formatter.sv
// Integer to ASCII formatter.
// Input stream (s_*): one word per conversion request; s_tuser picks the
// conversion (signed/unsigned decimal, hex, 0x-prefixed hex, literal) and
// the operand size, s_tdata carries the value and the restart flag.
// Output stream (m_*): one word per ASCII character, with its position in
// the running count and an in-limit flag; m_tlast marks the last character
// of each request. Config writes go through cfg_wr_en/cfg_index/cfg_wdata
// and must only happen while the block is idle.
// Sequencing: one request at a time. A decimal request is accepted, emits
// an optional minus sign, runs shift-and-add-3 over all VALUE_WIDTH bits,
// then skips leading zeros and outputs the digits (one character a cycle
// while the receiver keeps up). Hex skips leading zeros and outputs digits,
// after a 0x prefix for a pointer; a literal emits an optional CR, then the
// character. Each character appears on m_* the cycle after the state that
// emits it. A single output register sits on m_*; when the receiver stalls,
// the sequencer holds its current character until the register frees up.
// Reset (aresetn low, synchronous) clears the count, the previous literal
// character and the output valid, and restores the config defaults.
`default_nettype none

module integer_to_ascii_formatter #(
    parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [30:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // [63:0] value, [64] restart, [71:65] zero
    input  wire logic [4:0]  s_tuser,   // [2:0] action, [4:3] size_code
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [7:0] char_code, [8] in_limit, [39:9] position
    output logic             m_tlast
);

    itoa_pkg::cmd_t    cmd;
    itoa_pkg::status_t sts;

    itoa_ctrl #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .action   (s_tuser[2:0]),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    itoa_dpath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .action       (s_tuser[2:0]),
        .size_code    (s_tuser[4:3]),
        .value        (s_tdata[63:0]),
        .restart      (s_tdata[64]),
        .cmd          (cmd),
        .sts          (sts),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_char     (m_tdata[7:0]),
        .out_in_limit (m_tdata[8]),
        .out_position (m_tdata[39:9]),
        .out_last     (m_tlast)
    );

endmodule

`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int DRAIN_CYCLES = 128;
    localparam int RANDOM_PER_PHASE = 51;
    localparam int NUM_PHASES = 5;

    typedef struct packed {
        logic [2:0]  action;
        logic [1:0]  size;
        logic [63:0] value;
        logic        restart;
    } request_t;

    typedef struct packed {
        logic [7:0]                   code;
        logic                         in_limit;
        logic [itoa_pkg::COUNT_W-1:0] position;
        logic                         last;
    } char_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [0:0]  cfg_index = itoa_pkg::CFG_OUTPUT_LIMIT;
    logic [30:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [4:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;

    // Formatter state as seen from outside
    logic [itoa_pkg::COUNT_W-1:0] char_count = '0;
    logic [7:0]                   prev_literal = 8'h00;
    logic [itoa_pkg::COUNT_W-1:0] limit_reg = itoa_pkg::COUNT_MAX;
    logic                         crlf_on = 1'b0;

    request_t pending_requests[$];
    char_t    expected_chars[$];
    request_t in_flight;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int fail_count = 0;

    integer_to_ascii_formatter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Work out the characters one request produces and queue them.
    function automatic void format_request(input request_t req);
        logic [7:0]  seq [0:20];
        logic [7:0]  digits [0:19];
        logic [63:0] mask;
        logic [63:0] v;
        logic [63:0] rem;
        logic [3:0]  nib;
        logic [7:0]  ch;
        bit          started;
        int          width;
        int          n;
        int          k;
        int          i;
        char_t       c;
        n = 0;
        if (req.restart)
            char_count = '0;
        width = 8 << req.size;
        mask = (width == 64) ? '1 : ((64'd1 << width) - 64'd1);
        v = req.value & mask;
        case (req.action)
            itoa_pkg::ACT_SDEC, itoa_pkg::ACT_UDEC: begin
                if (req.action == itoa_pkg::ACT_SDEC && v[width-1]) begin
                    seq[n] = itoa_pkg::ASCII_MINUS;
                    n++;
                    v = (~v & mask) + 64'd1;
                end
                k = 0;
                if (v == 0) begin
                    digits[0] = itoa_pkg::ASCII_ZERO;
                    k = 1;
                end
                while (v != 0) begin
                    rem = v % 64'd10;
                    digits[k] = itoa_pkg::ASCII_ZERO + rem[7:0];
                    v = v / 64'd10;
                    k++;
                end
                for (i = k - 1; i >= 0; i--) begin
                    seq[n] = digits[i];
                    n++;
                end
            end
            itoa_pkg::ACT_HEX, itoa_pkg::ACT_PTR: begin
                if (req.action == itoa_pkg::ACT_PTR) begin
                    seq[n] = itoa_pkg::ASCII_ZERO;
                    seq[n+1] = itoa_pkg::ASCII_X;
                    n += 2;
                end
                started = 1'b0;
                for (i = 15; i >= 0; i--) begin
                    nib = v[4*i +: 4];
                    if (started || nib != 0 || i == 0) begin
                        started = 1'b1;
                        seq[n] = (nib < 4'd10)
                                 ? itoa_pkg::ASCII_ZERO + {4'd0, nib}
                                 : itoa_pkg::ASCII_UPPER + {4'd0, nib} - 8'd10;
                        n++;
                    end
                end
            end
            itoa_pkg::ACT_LIT: begin
                ch = req.value[7:0];
                if (crlf_on && ch == itoa_pkg::ASCII_LF
                    && prev_literal != itoa_pkg::ASCII_CR) begin
                    seq[n] = itoa_pkg::ASCII_CR;
                    n++;
                end
                prev_literal = ch;
                seq[n] = ch;
                n++;
            end
            default: ;
        endcase
        for (i = 0; i < n; i++) begin
            c.code = seq[i];
            c.in_limit = (char_count < limit_reg);
            c.position = char_count;
            c.last = (i == n - 1);
            expected_chars.push_back(c);
            if (char_count != itoa_pkg::COUNT_MAX)
                char_count++;
        end
    endfunction

    function automatic request_t random_request();
        request_t   req;
        logic [63:0] mask;
        logic [63:0] pattern;
        int width;
        int pick;
        req.restart = ($urandom_range(0, 7) == 0);
        req.size = 2'($urandom_range(0, 3));
        req.value = {$urandom, $urandom};
        width = 8 << req.size;
        mask = (width == 64) ? '1 : ((64'd1 << width) - 64'd1);
        pick = $urandom_range(0, 11);
        if (pick == 0)
            req.action = 3'($urandom_range(5, 7));
        else
            req.action = 3'($urandom_range(itoa_pkg::ACT_SDEC, itoa_pkg::ACT_LIT));
        if (req.action == itoa_pkg::ACT_LIT) begin
            pick = $urandom_range(0, 19);
            if (pick < 8)
                req.value[7:0] = itoa_pkg::ASCII_LF;
            else if (pick < 13)
                req.value[7:0] = itoa_pkg::ASCII_CR;
            return req;
        end
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return req;
        if (pick < 6) begin
            pattern = 64'($urandom_range(0, 20));
        end else if (pick == 6) begin
            case ($urandom_range(0, 3))
                0: pattern = 64'd1 << (width - 1);
                1: pattern = (64'd1 << (width - 1)) - 64'd1;
                2: pattern = '1;
                default: pattern = '0;
            endcase
        end else begin
            pattern = {$urandom, $urandom} >> $urandom_range(0, 63);
        end
        // keep junk above the selected width
        req.value = (req.value & ~mask) | (pattern & mask);
        return req;
    endfunction

    task automatic write_reg(input logic [0:0] idx, input logic [30:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == itoa_pkg::CFG_OUTPUT_LIMIT)
            limit_reg = data;
        else
            crlf_on = data[0];
    endtask

    task automatic wait_drained();
        while (pending_requests.size() != 0 || s_tvalid || expected_chars.size() != 0)
            @(negedge aclk);
        // unused actions emit nothing, so let the sequencer settle
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic add_request(input logic [2:0] action, input logic [1:0] size,
                               input logic [63:0] value, input logic restart);
        request_t req;
        req.action = action;
        req.size = size;
        req.value = value;
        req.restart = restart;
        pending_requests.push_back(req);
    endtask

    // Driver: advance to the next request once the current word is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid)
                format_request(in_flight);
            if (pending_requests.size() != 0
                && $urandom_range(0, 99) >= send_idle_pct) begin
                in_flight = pending_requests.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {7'd0, in_flight.restart, in_flight.value};
                s_tuser <= {in_flight.size, in_flight.action};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Monitor: compare each character word with the oldest expectation
    always @(posedge aclk) begin
        char_t got;
        char_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.code = m_tdata[7:0];
            got.in_limit = m_tdata[8];
            got.position = m_tdata[39:9];
            got.last = m_tlast;
            if (expected_chars.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected char: code %02h in_limit %0d pos %0d last %0d",
                             got.code, got.in_limit, got.position, got.last);
            end else begin
                want = expected_chars.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"mismatch: exp code %02h lim %0d pos %0d last %0d, ",
                                  "got code %02h lim %0d pos %0d last %0d"},
                                 want.code, want.in_limit, want.position, want.last,
                                 got.code, got.in_limit, got.position, got.last);
                end
            end
        end
    end

    initial begin
        int p;
        int j;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        write_reg(itoa_pkg::CFG_OUTPUT_LIMIT, itoa_pkg::COUNT_MAX);
        write_reg(itoa_pkg::CFG_CONVERT_NEWLINES, 31'd1);
        add_request(itoa_pkg::ACT_SDEC, itoa_pkg::SIZE_8,  64'h1234_5678_9ABC_DE80, 1'b0);
        add_request(itoa_pkg::ACT_SDEC, itoa_pkg::SIZE_8,  64'h0000_0000_0000_007F, 1'b0);
        add_request(itoa_pkg::ACT_SDEC, itoa_pkg::SIZE_64, 64'h8000_0000_0000_0000, 1'b0);
        add_request(itoa_pkg::ACT_SDEC, itoa_pkg::SIZE_64, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        add_request(itoa_pkg::ACT_UDEC, itoa_pkg::SIZE_64, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        add_request(itoa_pkg::ACT_UDEC, itoa_pkg::SIZE_16, 64'hAAAA_5555_0000_FFFF, 1'b0);
        add_request(itoa_pkg::ACT_UDEC, itoa_pkg::SIZE_32, 64'hFFFF_FFFF_0000_0000, 1'b0);
        add_request(itoa_pkg::ACT_SDEC, itoa_pkg::SIZE_32, 64'h0000_0000_0000_0000, 1'b0);
        add_request(itoa_pkg::ACT_HEX,  itoa_pkg::SIZE_64, 64'h0000_0000_0000_0000, 1'b0);
        add_request(itoa_pkg::ACT_HEX,  itoa_pkg::SIZE_64, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        add_request(itoa_pkg::ACT_PTR,  itoa_pkg::SIZE_16, 64'hFFFF_FFFF_FFFF_0000, 1'b0);
        add_request(itoa_pkg::ACT_PTR,  itoa_pkg::SIZE_32, 64'h0123_4567_DEAD_BEEF, 1'b0);
        add_request(itoa_pkg::ACT_HEX,  itoa_pkg::SIZE_8,  64'h0000_0000_0000_00A5, 1'b1);
        add_request(itoa_pkg::ACT_LIT,  itoa_pkg::SIZE_8,  {56'd0, itoa_pkg::ASCII_LF}, 1'b0);
        add_request(itoa_pkg::ACT_LIT,  itoa_pkg::SIZE_8,  {56'd0, itoa_pkg::ASCII_CR}, 1'b0);
        add_request(itoa_pkg::ACT_LIT,  itoa_pkg::SIZE_8,  {56'd0, itoa_pkg::ASCII_LF}, 1'b0);
        add_request(itoa_pkg::ACT_LIT,  itoa_pkg::SIZE_64,
                    {56'hFF_FFFF_FFFF_FFFF, itoa_pkg::ASCII_LF}, 1'b0);
        add_request(3'd5,               itoa_pkg::SIZE_64, 64'h0000_0000_0000_0001, 1'b1);
        add_request(3'd6,               itoa_pkg::SIZE_8,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        add_request(3'd7,               itoa_pkg::SIZE_32, 64'h0000_0000_0000_002A, 1'b0);
        add_request(itoa_pkg::ACT_LIT,  itoa_pkg::SIZE_16, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        add_request(itoa_pkg::ACT_UDEC, itoa_pkg::SIZE_8,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        add_request(itoa_pkg::ACT_SDEC, itoa_pkg::SIZE_16, 64'h0000_0000_0000_8000, 1'b0);
        wait_drained();

        for (p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin
                    send_idle_pct = 59; stall_pct = 0;
                    write_reg(itoa_pkg::CFG_OUTPUT_LIMIT, 31'd0);
                    write_reg(itoa_pkg::CFG_CONVERT_NEWLINES, 31'd0);
                end
                1: begin
                    send_idle_pct = 0; stall_pct = 59;
                    write_reg(itoa_pkg::CFG_OUTPUT_LIMIT, 31'($urandom_range(1, 60)));
                    write_reg(itoa_pkg::CFG_CONVERT_NEWLINES, 31'd1);
                end
                2: begin
                    send_idle_pct = 35; stall_pct = 35;
                    write_reg(itoa_pkg::CFG_OUTPUT_LIMIT, 31'($urandom_range(20, 150)));
                    write_reg(itoa_pkg::CFG_CONVERT_NEWLINES, 31'd0);
                end
                3: begin
                    send_idle_pct = 0; stall_pct = 0;
                    write_reg(itoa_pkg::CFG_OUTPUT_LIMIT, itoa_pkg::COUNT_MAX);
                    write_reg(itoa_pkg::CFG_CONVERT_NEWLINES, 31'd1);
                end
                default: begin
                    send_idle_pct = 35; stall_pct = 59;
                    write_reg(itoa_pkg::CFG_OUTPUT_LIMIT, 31'd1);
                    write_reg(itoa_pkg::CFG_CONVERT_NEWLINES, 31'd1);
                end
            endcase
            for (j = 0; j < RANDOM_PER_PHASE; j++)
                pending_requests.push_back(random_request());
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
